/* hdl/ltp_pkg.sv */
// Shared types, widths and defaults for the last-touch predictor.
// No dependencies; used by every other file of the block.
package ltp_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned SET_W  = 6;
  localparam int unsigned WAY_W  = 2;
  localparam int unsigned PC_W   = 32;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned SET_COUNT_DEF  = 64;
  localparam int unsigned NUM_WAYS_DEF   = 4;
  localparam int unsigned HIST_DEPTH_DEF = 4;

  localparam logic [CNT_W-1:0] LIMIT_RST = 4'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_END    = 2'd2,
    CMD_CHECK  = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_TRACE = 2'd1,
    STAT_OPEN     = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FRAME,
    ST_RD,
    ST_CMP,
    ST_FIN
  } state_e;

  // result of the shared add / compare unit
  typedef struct packed {
    logic [PC_W-1:0]  sum;
    logic             hit;
    logic             full;
    logic [CNT_W-1:0] cnt_next;
  } alu_out_t;

  function automatic int unsigned addr_w(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

/* hdl/ltp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on ltp_pkg for the address width helper.
module ltp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = ltp_pkg::addr_w(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/ltp_alu.sv */
// Shared arithmetic unit: hash add, history compare, counter saturation.
// Depends on ltp_pkg for widths and the result struct.
module ltp_alu (
  input  logic [ltp_pkg::PC_W-1:0]  add_a_i,
  input  logic [ltp_pkg::PC_W-1:0]  add_b_i,
  input  logic [ltp_pkg::PC_W-1:0]  key_i,
  input  logic [ltp_pkg::PC_W-1:0]  hash_i,
  input  logic [ltp_pkg::CNT_W-1:0] cnt_i,
  input  logic [ltp_pkg::CNT_W-1:0] limit_i,
  output ltp_pkg::alu_out_t         res_o
);

  always_comb begin
    res_o.sum      = add_a_i + add_b_i;
    res_o.hit      = (key_i == hash_i);
    res_o.full     = (cnt_i == limit_i);
    // counters above a lowered limit are left alone
    res_o.cnt_next = (cnt_i < limit_i) ? (cnt_i + 1'b1) : cnt_i;
  end

endmodule

/* hdl/last_touch_predictor.sv */
// Last-touch predictor: one command per request (start, append, end, check) on a
// cache frame (set, way). A request is taken when start is high and busy low; its
// result is on the result ports, done_o high for exactly one cycle; it cannot be
// held off. Start, append, the no-trace and out-of-range cases and an end of an
// untouched trace finish in the frame-read state, as does a check on an empty
// history. Check and the end of a touched trace walk the frame's history one slot
// at a time (read, then compare) through a single history RAM port and the shared
// compare unit. After reset the frame table is swept clear, one frame a cycle, and
// busy stays high until all SET_COUNT*NUM_WAYS frames are swept; confidence_limit
// may be written during that sweep.
//
// Top level: sequencer, config register, frame and history RAMs.
// Depends on ltp_pkg, ltp_ram and ltp_alu.
module last_touch_predictor #(
  parameter int unsigned SET_COUNT  = ltp_pkg::SET_COUNT_DEF,
  parameter int unsigned NUM_WAYS   = ltp_pkg::NUM_WAYS_DEF,
  parameter int unsigned HIST_DEPTH = ltp_pkg::HIST_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [ltp_pkg::CMD_W-1:0]   cmd_i,
  input  logic [ltp_pkg::SET_W-1:0]   set_index_i,
  input  logic [ltp_pkg::WAY_W-1:0]   way_i,
  input  logic [ltp_pkg::PC_W-1:0]    pc_i,
  input  logic                        cfg_we_i,
  input  logic [ltp_pkg::CNT_W-1:0]   cfg_wdata_i,
  output logic                        done_o,
  output logic                        last_touch_o,
  output logic                        new_trace_added_o,
  output logic [ltp_pkg::STAT_W-1:0]  status_o
);
  import ltp_pkg::*;

  localparam int unsigned NUM_FRAMES   = SET_COUNT * NUM_WAYS;
  localparam int unsigned HIST_ENTRIES = NUM_FRAMES * HIST_DEPTH;
  localparam int unsigned FRAME_AW     = addr_w(NUM_FRAMES);
  localparam int unsigned HIST_AW      = addr_w(HIST_ENTRIES);
  localparam int unsigned SLOT_W       = addr_w(HIST_DEPTH);
  localparam int unsigned FILL_W       = $clog2(HIST_DEPTH + 1);
  // frame entry: {open, touched, fill, hash}
  localparam int unsigned FE_W         = 2 + FILL_W + PC_W;
  // history entry: {hash, count}
  localparam int unsigned HE_W         = PC_W + CNT_W;

  localparam logic [FRAME_AW-1:0] LAST_FRAME = FRAME_AW'(NUM_FRAMES - 1);
  localparam logic [FILL_W-1:0]   FILL_MAX   = FILL_W'(HIST_DEPTH);
  localparam logic [HIST_AW-1:0]  HD_A       = HIST_AW'(HIST_DEPTH);
  localparam logic [31:0]         NS32       = 32'(SET_COUNT);
  localparam logic [31:0]         NW32       = 32'(NUM_WAYS);

  // sequencer state
  state_e              state_q, state_d;
  logic [FRAME_AW-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]    limit_q;

  // request context
  cmd_e                cmd_q, cmd_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic [FRAME_AW-1:0] frame_q, frame_d;
  logic                range_q, range_d;
  logic [PC_W-1:0]     key_q, key_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                found_q, found_d;
  logic                touch_q, touch_d;

  // result
  logic    emit;
  logic    emit_touch, emit_added;
  status_e emit_status;
  logic    done_q, last_touch_q, added_q;
  status_e status_q;

  // frame RAM
  logic                f_we;
  logic [FRAME_AW-1:0] f_waddr;
  logic [FE_W-1:0]     f_wdata;
  logic [FE_W-1:0]     f_rdata;
  logic                fe_open, fe_touched;
  logic [FILL_W-1:0]   fe_fill;
  logic [PC_W-1:0]     fe_hash;

  // history RAM
  logic                h_we;
  logic [HIST_AW-1:0]  h_waddr;
  logic [HE_W-1:0]     h_wdata;
  logic [HIST_AW-1:0]  h_raddr;
  logic [HE_W-1:0]     h_rdata;
  logic [HIST_AW-1:0]  hist_base, slot_addr, fill_addr;

  // input decode
  logic                in_range;
  logic [31:0]         in_prod;
  logic [FRAME_AW-1:0] in_frame;

  alu_out_t alu;

  assign in_range = (32'(set_index_i) < NS32) && (32'(way_i) < NW32);
  assign in_prod  = 32'(set_index_i) * NW32 + 32'(way_i);
  assign in_frame = in_prod[FRAME_AW-1:0];

  assign fe_open    = f_rdata[FE_W-1];
  assign fe_touched = f_rdata[FE_W-2];
  assign fe_fill    = f_rdata[PC_W +: FILL_W];
  assign fe_hash    = f_rdata[PC_W-1:0];

  assign hist_base = HIST_AW'(frame_q) * HD_A;
  assign slot_addr = hist_base + HIST_AW'(slot_q);
  assign fill_addr = hist_base + HIST_AW'(fill_q);
  assign h_raddr   = slot_addr;

  assign busy = (state_q != ST_IDLE);

  ltp_ram #(
    .WIDTH(FE_W),
    .DEPTH(NUM_FRAMES)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(f_waddr),
    .wdata_i(f_wdata),
    .raddr_i(in_frame),   // only looked at in the cycle after an accept
    .rdata_o(f_rdata)
  );

  ltp_ram #(
    .WIDTH(HE_W),
    .DEPTH(HIST_ENTRIES)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  // one adder for hash + pc, one comparator reused on every history slot
  ltp_alu u_alu (
    .add_a_i(fe_hash),
    .add_b_i(pc_q),
    .key_i  (key_q),
    .hash_i (h_rdata[HE_W-1:CNT_W]),
    .cnt_i  (h_rdata[CNT_W-1:0]),
    .limit_i(limit_q),
    .res_o  (alu)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    pc_d        = pc_q;
    frame_d     = frame_q;
    range_d     = range_q;
    key_d       = key_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    found_d     = found_q;
    touch_d     = touch_q;
    f_we        = 1'b0;
    f_waddr     = frame_q;
    f_wdata     = '0;
    h_we        = 1'b0;
    h_waddr     = slot_addr;
    h_wdata     = '0;
    emit        = 1'b0;
    emit_touch  = 1'b0;
    emit_added  = 1'b0;
    emit_status = STAT_OK;

    unique case (state_q)
      ST_CLEAR: begin
        // closed, untouched, empty history
        f_we    = 1'b1;
        f_waddr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LAST_FRAME) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          cmd_d   = cmd_e'(cmd_i);
          pc_d    = pc_i;
          frame_d = in_frame;
          range_d = in_range;
          state_d = ST_FRAME;
        end
      end

      ST_FRAME: begin
        fill_d  = fe_fill;
        slot_d  = '0;
        found_d = 1'b0;
        touch_d = 1'b0;
        state_d = ST_IDLE;
        if (!range_q) begin
          emit        = 1'b1;
          emit_status = STAT_NO_TRACE;
        end else if (cmd_q != CMD_START && !fe_open) begin
          emit        = 1'b1;
          emit_status = STAT_NO_TRACE;
        end else begin
          case (cmd_q)
            CMD_START: begin
              emit = 1'b1;
              if (fe_open) begin
                emit_status = STAT_OPEN;
              end else begin
                f_we    = 1'b1;
                f_wdata = {1'b1, 1'b0, fe_fill, PC_W'(0)};
              end
            end
            CMD_APPEND: begin
              emit    = 1'b1;
              f_we    = 1'b1;
              f_wdata = {1'b1, 1'b1, fe_fill, alu.sum};
            end
            CMD_END: begin
              key_d = fe_hash;
              if (!fe_touched) begin
                emit    = 1'b1;
                f_we    = 1'b1;
                f_wdata = {1'b0, 1'b0, fe_fill, PC_W'(0)};
              end else if (fe_fill == '0) begin
                state_d = ST_FIN;
              end else begin
                state_d = ST_RD;
              end
            end
            CMD_CHECK: begin
              key_d = alu.sum;
              if (fe_fill == '0) begin
                emit = 1'b1;
              end else begin
                state_d = ST_RD;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_RD: begin
        state_d = ST_CMP;
      end

      ST_CMP: begin
        if (alu.hit) begin
          found_d = 1'b1;
          if (cmd_q == CMD_END) begin
            h_we    = 1'b1;
            h_waddr = slot_addr;
            h_wdata = {key_q, alu.cnt_next};
          end
          if (alu.full) begin
            touch_d = 1'b1;
          end
        end
        slot_d = slot_q + 1'b1;
        if (FILL_W'(slot_q) + 1'b1 == fill_q) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_RD;
        end
      end

      ST_FIN: begin
        emit    = 1'b1;
        state_d = ST_IDLE;
        if (cmd_q == CMD_END) begin
          f_we    = 1'b1;
          f_wdata = {1'b0, 1'b0, fill_q, PC_W'(0)};
          if (!found_q) begin
            if (fill_q != FILL_MAX) begin
              // new entry goes to the first free slot
              h_we       = 1'b1;
              h_waddr    = fill_addr;
              h_wdata    = {key_q, CNT_W'(0)};
              f_wdata    = {1'b0, 1'b0, fill_q + 1'b1, PC_W'(0)};
              emit_added = 1'b1;
            end else begin
              emit_status = STAT_FULL;
            end
          end
        end else begin
          emit_touch = touch_q;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      limit_q <= LIMIT_RST;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= emit;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    pc_q    <= pc_d;
    frame_q <= frame_d;
    range_q <= range_d;
    key_q   <= key_d;
    fill_q  <= fill_d;
    slot_q  <= slot_d;
    found_q <= found_d;
    touch_q <= touch_d;
    if (emit) begin
      last_touch_q <= emit_touch;
      added_q      <= emit_added;
      status_q     <= emit_status;
    end
  end

  assign done_o            = done_q;
  assign last_touch_o      = last_touch_q;
  assign new_trace_added_o = added_q;
  assign status_o          = status_q;

endmodule

/* hdl/ltp_checker.sv */
// Port-level checks on the last-touch predictor, bound to the top level.
// Depends on ltp_pkg and last_touch_predictor.
module ltp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_i,
  input logic                       done_i,
  input logic                       last_touch_i,
  input logic                       new_trace_added_i,
  input logic [ltp_pkg::STAT_W-1:0] status_i
);
  import ltp_pkg::*;

  // a taken request always raises busy in the cycle after it is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("busy low right after a request");

  // at most one result per request; the result strobe is never high back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("result strobe held two cycles");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(busy_i))
    else $error("result without a request in flight");

  a_touch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && last_touch_i |-> (status_i == STAT_OK) && !new_trace_added_i)
    else $error("last touch with bad status or new entry");

  a_added_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && new_trace_added_i |-> status_i == STAT_OK)
    else $error("new entry reported with error status");

endmodule

bind last_touch_predictor ltp_checker u_ltp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start),
  .busy_i           (busy),
  .done_i           (done_o),
  .last_touch_i     (last_touch_o),
  .new_trace_added_i(new_trace_added_o),
  .status_i         (status_o)
);

/* dv/last_touch_predictor_tb.sv */
// Testbench for last_touch_predictor: drives start/append/end/check requests on cache
// frames and checks every result against a scoreboard that tracks trace signatures.
// Depends on ltp_pkg and the RTL of last_touch_predictor.
`timescale 1ns / 1ps

module last_touch_predictor_tb;
  import ltp_pkg::*;

  localparam int unsigned NUM_FRAMES = SET_COUNT_DEF * NUM_WAYS_DEF;
  localparam int unsigned DEPTH      = HIST_DEPTH_DEF;

  // what one request should come back with
  typedef struct packed {
    logic    touch;
    logic    added;
    status_e status;
  } verdict_t;

  // Tracks open signatures and per-frame history exactly as the block should, and
  // keeps the verdicts of accepted requests in order until their results show up.
  class last_touch_scoreboard;
    logic [CNT_W-1:0] limit;
    bit               frame_open    [NUM_FRAMES];
    bit               frame_touched [NUM_FRAMES];
    bit [PC_W-1:0]    frame_hash    [NUM_FRAMES];
    bit               slot_valid    [NUM_FRAMES][DEPTH];
    bit [PC_W-1:0]    slot_hash     [NUM_FRAMES][DEPTH];
    bit [CNT_W-1:0]   slot_count    [NUM_FRAMES][DEPTH];
    verdict_t         pending_verdicts[$];
    int unsigned      errors;

    function new();
      limit  = LIMIT_RST;
      errors = 0;
    endfunction

    function void note_request(cmd_e c, bit [SET_W-1:0] s, bit [WAY_W-1:0] w,
                               bit [PC_W-1:0] p);
      verdict_t      v;
      int unsigned   f;
      bit            found;
      bit            stored;
      bit [PC_W-1:0] probe;
      v      = '{touch: 1'b0, added: 1'b0, status: STAT_OK};
      f      = s * NUM_WAYS_DEF + w;
      found  = 1'b0;
      stored = 1'b0;
      if (c == CMD_START) begin
        if (frame_open[f]) begin
          v.status = STAT_OPEN;
        end else begin
          frame_open[f]    = 1'b1;
          frame_touched[f] = 1'b0;
          frame_hash[f]    = '0;
        end
      end else if (!frame_open[f]) begin
        v.status = STAT_NO_TRACE;
      end else if (c == CMD_APPEND) begin
        frame_hash[f]    = frame_hash[f] + p;
        frame_touched[f] = 1'b1;
      end else if (c == CMD_END) begin
        if (frame_touched[f]) begin
          // every matching slot gains confidence, not just the first
          for (int i = 0; i < DEPTH; i++) begin
            if (slot_valid[f][i] && slot_hash[f][i] == frame_hash[f]) begin
              if (slot_count[f][i] < limit) slot_count[f][i]++;
              found = 1'b1;
            end
          end
          if (!found) begin
            for (int i = 0; i < DEPTH && !stored; i++) begin
              if (!slot_valid[f][i]) begin
                slot_valid[f][i] = 1'b1;
                slot_hash[f][i]  = frame_hash[f];
                slot_count[f][i] = '0;
                stored           = 1'b1;
              end
            end
            if (stored) v.added = 1'b1;
            else        v.status = STAT_FULL;
          end
        end
        frame_open[f]    = 1'b0;
        frame_touched[f] = 1'b0;
        frame_hash[f]    = '0;
      end else begin
        probe = frame_hash[f] + p;
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_valid[f][i] && slot_hash[f][i] == probe && slot_count[f][i] == limit)
            v.touch = 1'b1;
        end
      end
      pending_verdicts = {pending_verdicts, v};
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic touch, logic added, logic [STAT_W-1:0] status);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        v = pending_verdicts.pop_front();
        if (touch !== v.touch)
          report_mismatch($sformatf("last_touch %b, want %b", touch, v.touch));
        if (added !== v.added)
          report_mismatch($sformatf("new_trace_added %b, want %b", added, v.added));
        if (status !== v.status)
          report_mismatch($sformatf("status %0d, want %0d", status, v.status));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    cmd_i;
  logic [SET_W-1:0]    set_index_i;
  logic [WAY_W-1:0]    way_i;
  logic [PC_W-1:0]     pc_i;
  logic                cfg_we_i;
  logic [CNT_W-1:0]    cfg_wdata_i;
  logic                done_o;
  logic                last_touch_o;
  logic                new_trace_added_o;
  logic [STAT_W-1:0]   status_o;

  last_touch_predictor dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .cmd_i             (cmd_i),
    .set_index_i       (set_index_i),
    .way_i             (way_i),
    .pc_i              (pc_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .done_o            (done_o),
    .last_touch_o      (last_touch_o),
    .new_trace_added_o (new_trace_added_o),
    .status_o          (status_o)
  );

  last_touch_scoreboard sb;

  int unsigned   idle_pct;     // chance in 100 of a gap after each request
  int unsigned   items_sent;
  bit [PC_W-1:0] fav_pc  [6];  // per hot frame, the one-PC trace that repeats most
  bit [PC_W-1:0] pc_pool [4];  // shared PCs for mixed traces

  // hot frames for the random traces; the first one is the directed frame
  bit [SET_W-1:0] hot_set [6] = '{6'd63, 6'd0, 6'd17, 6'd42, 6'd5, 6'd60};
  bit [WAY_W-1:0] hot_way [6] = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Results cannot be held off, so every done cycle is taken as is. Sampling at the
  // rising edge sees the values of the cycle that this edge ends.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(last_touch_o, new_trace_added_o, status_o);
  end

  // One request: held until taken (start high, busy low at an edge). The prediction
  // is made at the accepting edge; the block works one request at a time, so the
  // scoreboard state always matches what the block sees. Start stays high into the
  // next request unless a gap is drawn.
  task automatic issue(cmd_e c, bit [SET_W-1:0] s, bit [WAY_W-1:0] w, bit [PC_W-1:0] p);
    start       <= 1'b1;
    cmd_i       <= c;
    set_index_i <= s;
    way_i       <= w;
    pc_i        <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(c, s, w, p);
    items_sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every outstanding result and for the block to go idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_verdicts.size() != 0 || busy) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Limit changes only with nothing in flight.
  task automatic write_limit(bit [CNT_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.limit     = v;
  endtask

  // One trace on a hot frame: start, some appends, maybe a check aimed at a stored
  // signature, usually an end. A few requests are plain noise on any frame.
  task automatic run_trace(int unsigned pool);
    int unsigned    k;
    int unsigned    f;
    int unsigned    j;
    int unsigned    n_app;
    bit [SET_W-1:0] s;
    bit [WAY_W-1:0] w;
    bit [PC_W-1:0]  p;
    if ($urandom_range(99) < 12) begin
      issue(cmd_e'($urandom_range(3)), SET_W'($urandom_range(63)),
            WAY_W'($urandom_range(3)), $urandom());
    end else begin
      k = $urandom_range(pool - 1);
      s = hot_set[k];
      w = hot_way[k];
      f = s * NUM_WAYS_DEF + w;
      // a start on a still-open trace just reports it and keeps the trace going
      issue(CMD_START, s, w, $urandom());
      if ($urandom_range(99) < 75) begin
        issue(CMD_APPEND, s, w, fav_pc[k]);
      end else begin
        n_app = $urandom_range(2);
        repeat (n_app) issue(CMD_APPEND, s, w, pc_pool[$urandom_range(3)]);
      end
      if ($urandom_range(1)) begin
        j = $urandom_range(DEPTH - 1);
        // aim hash + pc at a stored signature most of the time
        if (sb.slot_valid[f][j] && $urandom_range(99) < 70)
          p = sb.slot_hash[f][j] - sb.frame_hash[f];
        else
          p = $urandom();
        issue(CMD_CHECK, s, w, p);
      end
      if ($urandom_range(99) < 90) issue(CMD_END, s, w, $urandom());
    end
  endtask

  initial begin
    int unsigned    phase_limit [4];
    int unsigned    phase_idle  [4];
    int unsigned    phase_pool  [4];
    int unsigned    target;
    bit [SET_W-1:0] sa;
    bit [WAY_W-1:0] wa;

    phase_limit = '{15, 4, 1, 2};
    phase_idle  = '{0, 76, 16, 0};
    phase_pool  = '{2, 4, 6, 3};
    sb          = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = CMD_START;
    set_index_i = '0;
    way_i       = '0;
    pc_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    idle_pct    = 0;
    items_sent  = 0;
    foreach (fav_pc[i])  fav_pc[i]  = $urandom();
    foreach (pc_pool[i]) pc_pool[i] = $urandom();
    fav_pc[0] = 32'd7;  // matches a signature the directed part leaves on its frame
    sa = 6'd63;
    wa = 2'd3;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the frame table sweep after reset keeps busy high
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    // Directed part, limit at 1 so one repeat reaches full confidence.
    write_limit(4'd1);
    // no open trace on the lowest frame
    issue(CMD_CHECK,  6'd0, 2'd0, 32'hFFFF_FFFF);
    issue(CMD_APPEND, 6'd0, 2'd0, 32'h0);
    issue(CMD_END,    6'd0, 2'd0, 32'h0);
    // start twice, then end an untouched trace
    issue(CMD_START,  sa, wa, 32'h0);
    issue(CMD_START,  sa, wa, 32'h0);
    issue(CMD_END,    sa, wa, 32'h0);
    // hash wraps to zero: first history entry
    issue(CMD_START,  sa, wa, 32'h0);
    issue(CMD_APPEND, sa, wa, 32'hFFFF_FFFF);
    issue(CMD_APPEND, sa, wa, 32'h1);
    issue(CMD_END,    sa, wa, 32'h0);
    // three more distinct signatures fill the history
    issue(CMD_START,  sa, wa, 32'h0);
    issue(CMD_APPEND, sa, wa, 32'd7);
    issue(CMD_END,    sa, wa, 32'h0);
    issue(CMD_START,  sa, wa, 32'h0);
    issue(CMD_APPEND, sa, wa, 32'd8);
    issue(CMD_END,    sa, wa, 32'h0);
    issue(CMD_START,  sa, wa, 32'h0);
    issue(CMD_APPEND, sa, wa, 32'hFFFF_FFFF);
    issue(CMD_END,    sa, wa, 32'h0);
    // full history, no match: dropped
    issue(CMD_START,  sa, wa, 32'h0);
    issue(CMD_APPEND, sa, wa, 32'd9);
    issue(CMD_END,    sa, wa, 32'h0);
    // repeat of the zero signature raises its counter to the limit
    issue(CMD_START,  sa, wa, 32'h0);
    issue(CMD_APPEND, sa, wa, 32'h0);
    issue(CMD_END,    sa, wa, 32'h0);
    // zero hits at full confidence; seven hits an entry still at 0
    issue(CMD_START,  sa, wa, 32'h0);
    issue(CMD_CHECK,  sa, wa, 32'h0);
    issue(CMD_CHECK,  sa, wa, 32'd7);
    issue(CMD_END,    sa, wa, 32'h0);

    // Random traces in phases. Each limit change drains first; going from 15 down
    // leaves counters above the new limit.
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(CNT_W'(phase_limit[ph]));
      idle_pct = phase_idle[ph];
      target   = items_sent + 155;
      while (items_sent < target) run_trace(phase_pool[ph]);
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS last_touch_predictor");
    end else begin
      $display("FAIL last_touch_predictor");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL last_touch_predictor");
    $finish;
  end

endmodule
